### rtl/core/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared codes and control types of the triangle plane splitter.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_PT_X  = 3'd0;
  localparam logic [2:0] REG_PT_Y  = 3'd1;
  localparam logic [2:0] REG_PT_Z  = 3'd2;
  localparam logic [2:0] REG_NRM_X = 3'd3;
  localparam logic [2:0] REG_NRM_Y = 3'd4;
  localparam logic [2:0] REG_NRM_Z = 3'd5;

  // Piece kinds on the result port.
  localparam logic [1:0] KIND_NEG = 2'd0;
  localparam logic [1:0] KIND_POS = 2'd1;
  localparam logic [1:0] KIND_SEG = 2'd2;

  // How a triangle lies against the plane.
  typedef enum logic [2:0] {
    CS_NEG = 3'd0,  // no vertex on the positive side
    CS_POS = 3'd1,  // no vertex on the negative side
    CS_AB  = 3'd2,  // A and B share a strict side, C opposite
    CS_AC  = 3'd3,  // A and C share a strict side, B opposite
    CS_BC  = 3'd4,  // B and C share a strict side, A opposite
    CS_ZA  = 3'd5,  // only A on the plane
    CS_ZB  = 3'd6,  // only B on the plane
    CS_ZC  = 3'd7   // only C on the plane
  } case_e;

  // Vertex sources of an emitted piece.
  typedef enum logic [2:0] {
    SEL_A    = 3'd0,
    SEL_B    = 3'd1,
    SEL_C    = 3'd2,
    SEL_P    = 3'd3,
    SEL_Q    = 3'd4,
    SEL_ZERO = 3'd5
  } sel_e;

  // Classification that travels with a triangle down the pipeline.
  typedef struct packed {
    case_e cs;
    logic  a_neg;
    logic  b_neg;
    logic  c_neg;
    logic  a_zero;
    logic  b_zero;
    logic  c_zero;
  } plan_t;

endpackage

### rtl/core/triangle_plane_splitter.sv
// ----------------------------------------------------------------------------
// triangle_plane_splitter
// Splits a triangle by a configured plane into side-labelled triangles and
// the cut segment, with exact classification and truncated cut points.
//
//  Channel   Handshake            Payload
//  config    cfg_we_i             cfg_idx_i, cfg_data_i
//  triangle  start / busy         a_*_i, b_*_i, c_*_i
//  piece     strobe               piece_kind_o, v0/v1/v2_*_o, last_piece_o
//
// A triangle is taken when start is high and busy is low; one may follow in
// every cycle. A first piece passes two product/sum stages, a setup stage,
// COORD_BITS divider stages, the offset add, the hold register of the piece
// sequencer and the output register. The sequencer sends one piece per
// cycle, and a triangle has 1 to 4 pieces; that sets the sustained rate.
// While the sequencer still has pieces to send and a finished triangle waits,
// the whole pipeline holds and busy is high. Reset clears all valid bits and
// loads the plane registers; the receiver cannot stall the piece port.
// ----------------------------------------------------------------------------
module triangle_plane_splitter #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [COORD_BITS-1:0]  cfg_data_i,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_BITS-1:0]  a_x_i,
  input  logic [COORD_BITS-1:0]  a_y_i,
  input  logic [COORD_BITS-1:0]  a_z_i,
  input  logic [COORD_BITS-1:0]  b_x_i,
  input  logic [COORD_BITS-1:0]  b_y_i,
  input  logic [COORD_BITS-1:0]  b_z_i,
  input  logic [COORD_BITS-1:0]  c_x_i,
  input  logic [COORD_BITS-1:0]  c_y_i,
  input  logic [COORD_BITS-1:0]  c_z_i,
  output logic                   strobe,
  output logic [1:0]             piece_kind_o,
  output logic [COORD_BITS-1:0]  v0_x_o,
  output logic [COORD_BITS-1:0]  v0_y_o,
  output logic [COORD_BITS-1:0]  v0_z_o,
  output logic [COORD_BITS-1:0]  v1_x_o,
  output logic [COORD_BITS-1:0]  v1_y_o,
  output logic [COORD_BITS-1:0]  v1_z_o,
  output logic [COORD_BITS-1:0]  v2_x_o,
  output logic [COORD_BITS-1:0]  v2_y_o,
  output logic [COORD_BITS-1:0]  v2_z_o,
  output logic                   last_piece_o
);

  localparam int CW = COORD_BITS;
  localparam int DW = 2 * CW + 3;
  localparam int EW = DW + 1;
  localparam int LD = CW + 1;
  localparam logic [CW-1:0] NRM_Z_RST = CW'(64'd1 << FRAC_BITS);

  logic [2:0][CW-1:0]       pt_q;
  logic [2:0][CW-1:0]       nrm_q;
  logic [2:0][2:0][CW-1:0]  vtx_in;
  logic                     adv;

  logic                     side_val;
  logic [2:0][2:0][CW-1:0]  side_vtx;
  logic [2:0][DW-1:0]       side_d;

  logic                     plan_val;
  tps_pkg::plan_t           plan;
  logic [2:0][2:0][CW-1:0]  plan_vtx;
  logic [5:0][CW-1:0]       base;
  logic [5:0][CW-1:0]       smag;
  logic [5:0]               sneg;
  logic [1:0][DW-1:0]       dmag;
  logic [1:0][EW-1:0]       denmag;

  logic                     line_val_q  [LD];
  tps_pkg::plan_t           line_plan_q [LD];
  logic [2:0][2:0][CW-1:0]  line_vtx_q  [LD];
  logic [1:0][2:0][CW-1:0]  cut;

  logic                     emit_ready;
  logic [2:0][2:0][CW-1:0]  v_out;

  // The pipeline moves unless a finished triangle waits on the sequencer.
  assign adv  = !(line_val_q[LD-1] && !emit_ready);
  assign busy = !adv;

  assign vtx_in[0] = {c_z_i, c_y_i, c_x_i} == '0 ? {a_z_i, a_y_i, a_x_i}
                                                 : {a_z_i, a_y_i, a_x_i};
  assign vtx_in[1] = {b_z_i, b_y_i, b_x_i};
  assign vtx_in[2] = {c_z_i, c_y_i, c_x_i};

  // Plane registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q     <= '0;
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= NRM_Z_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tps_pkg::REG_PT_X:  pt_q[0]  <= cfg_data_i;
        tps_pkg::REG_PT_Y:  pt_q[1]  <= cfg_data_i;
        tps_pkg::REG_PT_Z:  pt_q[2]  <= cfg_data_i;
        tps_pkg::REG_NRM_X: nrm_q[0] <= cfg_data_i;
        tps_pkg::REG_NRM_Y: nrm_q[1] <= cfg_data_i;
        tps_pkg::REG_NRM_Z: nrm_q[2] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tps_side #(.CW(CW)) u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (start),
    .vtx_i   (vtx_in),
    .pt_i    (pt_q),
    .nrm_i   (nrm_q),
    .valid_o (side_val),
    .vtx_o   (side_vtx),
    .side_o  (side_d)
  );

  tps_plan #(.CW(CW)) u_plan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (side_val),
    .vtx_i    (side_vtx),
    .side_i   (side_d),
    .valid_o  (plan_val),
    .plan_o   (plan),
    .vtx_o    (plan_vtx),
    .base_o   (base),
    .smag_o   (smag),
    .neg_o    (sneg),
    .dmag_o   (dmag),
    .denmag_o (denmag)
  );

  // Six lanes: x, y, z of cut point P, then of cut point Q.
  for (genvar l = 0; l < 6; l++) begin : g_lane
    tps_cut_lane #(.CW(CW)) u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .base_i   (base[l]),
      .smag_i   (smag[l]),
      .neg_i    (sneg[l]),
      .dmag_i   (dmag[l/3]),
      .denmag_i (denmag[l/3]),
      .coord_o  (cut[l/3][l%3])
    );
  end

  // Context line that runs beside the divider lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < LD; j++) begin
        line_val_q[j] <= 1'b0;
      end
    end else if (adv) begin
      line_val_q[0] <= plan_val;
      for (int j = 1; j < LD; j++) begin
        line_val_q[j] <= line_val_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      line_plan_q[0] <= plan;
      line_vtx_q[0]  <= plan_vtx;
      for (int j = 1; j < LD; j++) begin
        line_plan_q[j] <= line_plan_q[j-1];
        line_vtx_q[j]  <= line_vtx_q[j-1];
      end
    end
  end

  tps_emit #(.CW(CW)) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (line_val_q[LD-1]),
    .plan_i   (line_plan_q[LD-1]),
    .vtx_i    (line_vtx_q[LD-1]),
    .cut_i    (cut),
    .ready_o  (emit_ready),
    .strobe_o (strobe),
    .kind_o   (piece_kind_o),
    .v_o      (v_out),
    .last_o   (last_piece_o)
  );

  assign v0_x_o = v_out[0][0];
  assign v0_y_o = v_out[0][1];
  assign v0_z_o = v_out[0][2];
  assign v1_x_o = v_out[1][0];
  assign v1_y_o = v_out[1][1];
  assign v1_z_o = v_out[1][2];
  assign v2_x_o = v_out[2][0];
  assign v2_y_o = v_out[2][1];
  assign v2_z_o = v_out[2][2];

endmodule

### rtl/core/tps_side.sv
// ----------------------------------------------------------------------------
// tps_side
// Two pipeline stages: the normal products, then the signed plane distance
// of each vertex, exact at full width.
// ----------------------------------------------------------------------------
module tps_side #(
  parameter int CW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][2:0][CW-1:0]       vtx_i,
  input  logic [2:0][CW-1:0]            pt_i,
  input  logic [2:0][CW-1:0]            nrm_i,
  output logic                          valid_o,
  output logic [2:0][2:0][CW-1:0]       vtx_o,
  output logic [2:0][2*CW+2:0]          side_o
);

  localparam int PW = 2 * CW;
  localparam int DW = 2 * CW + 3;

  logic signed [PW-1:0]     prod_d [12];
  logic signed [PW-1:0]     prod_q [12];
  logic [2:0][2:0][CW-1:0]  vtx1_q;
  logic                     val1_q;
  logic signed [DW-1:0]     side_d [3];
  logic [2:0][DW-1:0]       side_q;
  logic [2:0][2:0][CW-1:0]  vtx2_q;
  logic                     val2_q;

  // Products of the normal with every vertex and with the plane point.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[i*3+k] = $signed(nrm_i[k]) * $signed(vtx_i[i][k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      prod_d[9+k] = $signed(nrm_i[k]) * $signed(pt_i[k]);
    end
  end

  // Distance of each vertex: n.P - n.O.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_d[i] = DW'(prod_q[3*i]) + DW'(prod_q[3*i+1]) + DW'(prod_q[3*i+2])
                - DW'(prod_q[9]) - DW'(prod_q[10]) - DW'(prod_q[11]);
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val1_q <= 1'b0;
      val2_q <= 1'b0;
    end else if (en_i) begin
      val1_q <= valid_i;
      val2_q <= val1_q;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      vtx1_q <= vtx_i;
      vtx2_q <= vtx1_q;
      for (int i = 0; i < 3; i++) begin
        side_q[i] <= side_d[i];
      end
    end
  end

  assign valid_o = val2_q;
  assign vtx_o   = vtx2_q;
  assign side_o  = side_q;

endmodule

### rtl/core/tps_plan.sv
// ----------------------------------------------------------------------------
// tps_plan
// One pipeline stage that classifies the vertices, picks the edges to cut
// and sets up the magnitudes and signs for the six divider lanes.
// ----------------------------------------------------------------------------
module tps_plan #(
  parameter int CW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][2:0][CW-1:0]       vtx_i,
  input  logic [2:0][2*CW+2:0]          side_i,
  output logic                          valid_o,
  output tps_pkg::plan_t                plan_o,
  output logic [2:0][2:0][CW-1:0]       vtx_o,
  output logic [5:0][CW-1:0]            base_o,
  output logic [5:0][CW-1:0]            smag_o,
  output logic [5:0]                    neg_o,
  output logic [1:0][2*CW+2:0]          dmag_o,
  output logic [1:0][2*CW+3:0]          denmag_o
);

  localparam int DW = 2 * CW + 3;
  localparam int EW = DW + 1;
  localparam int SW = CW + 1;

  logic [2:0]               neg;
  logic [2:0]               zero;
  logic [2:0]               pos;
  tps_pkg::plan_t           plan_d;
  logic [1:0]               from_idx [2];
  logic [1:0]               to_idx [2];
  logic signed [DW-1:0]     d1 [2];
  logic signed [EW-1:0]     den [2];
  logic [DW-1:0]            d1_neg [2];
  logic [EW-1:0]            den_neg [2];
  logic signed [SW-1:0]     diff [6];
  logic [SW-1:0]            diff_neg [6];
  logic [5:0][CW-1:0]       base_d;
  logic [5:0][CW-1:0]       smag_d;
  logic [5:0]               sgn_d;
  logic [1:0][DW-1:0]       dmag_d;
  logic [1:0][EW-1:0]       denmag_d;

  logic                     val_q;
  tps_pkg::plan_t           plan_q;
  logic [2:0][2:0][CW-1:0]  vtx_q;
  logic [5:0][CW-1:0]       base_q;
  logic [5:0][CW-1:0]       smag_q;
  logic [5:0]               sgn_q;
  logic [1:0][DW-1:0]       dmag_q;
  logic [1:0][EW-1:0]       denmag_q;

  // Side of each vertex and the case that the triangle falls in.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i]  = side_i[i][DW-1];
      zero[i] = (side_i[i] == '0);
      pos[i]  = !neg[i] && !zero[i];
    end
    plan_d.a_neg  = neg[0];
    plan_d.b_neg  = neg[1];
    plan_d.c_neg  = neg[2];
    plan_d.a_zero = zero[0];
    plan_d.b_zero = zero[1];
    plan_d.c_zero = zero[2];
    if (pos == 3'b000) begin
      plan_d.cs = tps_pkg::CS_NEG;
    end else if (neg == 3'b000) begin
      plan_d.cs = tps_pkg::CS_POS;
    end else if (zero == 3'b000) begin
      if (neg[0] == neg[1]) begin
        plan_d.cs = tps_pkg::CS_AB;
      end else if (neg[0] == neg[2]) begin
        plan_d.cs = tps_pkg::CS_AC;
      end else begin
        plan_d.cs = tps_pkg::CS_BC;
      end
    end else if (zero[0]) begin
      plan_d.cs = tps_pkg::CS_ZA;
    end else if (zero[1]) begin
      plan_d.cs = tps_pkg::CS_ZB;
    end else begin
      plan_d.cs = tps_pkg::CS_ZC;
    end
  end

  // Edge endpoints of the two cut points P and Q.
  always_comb begin
    from_idx[0] = 2'd1;
    to_idx[0]   = 2'd2;
    from_idx[1] = 2'd0;
    to_idx[1]   = 2'd2;
    case (plan_d.cs)
      tps_pkg::CS_AC: begin
        from_idx[0] = 2'd2;
        to_idx[0]   = 2'd1;
        from_idx[1] = 2'd0;
        to_idx[1]   = 2'd1;
      end
      tps_pkg::CS_BC: begin
        from_idx[0] = 2'd2;
        to_idx[0]   = 2'd0;
        from_idx[1] = 2'd1;
        to_idx[1]   = 2'd0;
      end
      tps_pkg::CS_ZB: begin
        from_idx[0] = 2'd2;
        to_idx[0]   = 2'd0;
      end
      tps_pkg::CS_ZC: begin
        from_idx[0] = 2'd0;
        to_idx[0]   = 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Magnitudes and offset signs for the lanes.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      d1[p]       = $signed(side_i[from_idx[p]]);
      den[p]      = EW'($signed(side_i[from_idx[p]])) - EW'($signed(side_i[to_idx[p]]));
      d1_neg[p]   = -d1[p];
      den_neg[p]  = -den[p];
      dmag_d[p]   = d1[p][DW-1] ? d1_neg[p] : d1[p];
      denmag_d[p] = den[p][EW-1] ? den_neg[p] : den[p];
      for (int k = 0; k < 3; k++) begin
        diff[p*3+k] = SW'($signed(vtx_i[to_idx[p]][k]))
                    - SW'($signed(vtx_i[from_idx[p]][k]));
        diff_neg[p*3+k] = -diff[p*3+k];
        smag_d[p*3+k] = diff[p*3+k][SW-1] ? diff_neg[p*3+k][CW-1:0]
                                          : diff[p*3+k][CW-1:0];
        sgn_d[p*3+k]  = diff[p*3+k][SW-1] ^ d1[p][DW-1] ^ den[p][EW-1];
        base_d[p*3+k] = vtx_i[from_idx[p]][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
    end else if (en_i) begin
      val_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plan_q   <= plan_d;
      vtx_q    <= vtx_i;
      base_q   <= base_d;
      smag_q   <= smag_d;
      sgn_q    <= sgn_d;
      dmag_q   <= dmag_d;
      denmag_q <= denmag_d;
    end
  end

  assign valid_o  = val_q;
  assign plan_o   = plan_q;
  assign vtx_o    = vtx_q;
  assign base_o   = base_q;
  assign smag_o   = smag_q;
  assign neg_o    = sgn_q;
  assign dmag_o   = dmag_q;
  assign denmag_o = denmag_q;

endmodule

### rtl/core/tps_cut_lane.sv
// ----------------------------------------------------------------------------
// tps_cut_lane
// One coordinate of a cut point: base + trunc(s * d1 / den), computed by a
// pipelined long division that takes one bit of |s| per stage, then a final
// stage that applies the sign and adds the base.
// ----------------------------------------------------------------------------
module tps_cut_lane #(
  parameter int CW = 32
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CW-1:0]     base_i,
  input  logic [CW-1:0]     smag_i,
  input  logic              neg_i,
  input  logic [2*CW+2:0]   dmag_i,
  input  logic [2*CW+3:0]   denmag_i,
  output logic [CW-1:0]     coord_o
);

  localparam int DW = 2 * CW + 3;
  localparam int EW = DW + 1;
  localparam int TW = EW + 2;

  logic [EW-1:0] rem_q  [CW];
  logic [CW-1:0] quo_q  [CW];
  logic [CW-1:0] s_q    [CW];
  logic [DW-1:0] d_q    [CW];
  logic [EW-1:0] den_q  [CW];
  logic          neg_q  [CW];
  logic [CW-1:0] base_q [CW];
  logic [CW-1:0] coord_q;
  logic [CW-1:0] quo_neg;

  // Each stage keeps rem < den; the partial sum 2*rem + bit*|d1| stays
  // below three times den, so a quotient digit is 0, 1 or 2.
  for (genvar j = 0; j < CW; j++) begin : g_st
    logic [EW-1:0] rem_in;
    logic [CW-1:0] quo_in;
    logic [CW-1:0] s_in;
    logic [DW-1:0] d_in;
    logic [EW-1:0] den_in;
    logic          neg_in;
    logic [CW-1:0] base_in;
    logic [TW-1:0] acc;
    logic [TW-1:0] den1;
    logic [TW-1:0] den2;
    logic [TW-1:0] rem_nx;
    logic [CW-1:0] quo_nx;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign s_in    = smag_i;
      assign d_in    = dmag_i;
      assign den_in  = denmag_i;
      assign neg_in  = neg_i;
      assign base_in = base_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign s_in    = s_q[j-1];
      assign d_in    = d_q[j-1];
      assign den_in  = den_q[j-1];
      assign neg_in  = neg_q[j-1];
      assign base_in = base_q[j-1];
    end

    always_comb begin
      acc  = {1'b0, rem_in, 1'b0} + (s_in[CW-1] ? TW'(d_in) : '0);
      den1 = TW'(den_in);
      den2 = {1'b0, den_in, 1'b0};
      if (acc >= den2) begin
        rem_nx = acc - den2;
        quo_nx = {quo_in[CW-2:0], 1'b0} + CW'(2);
      end else if (acc >= den1) begin
        rem_nx = acc - den1;
        quo_nx = {quo_in[CW-2:0], 1'b1};
      end else begin
        rem_nx = acc;
        quo_nx = {quo_in[CW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_nx[EW-1:0];
        quo_q[j]  <= quo_nx;
        s_q[j]    <= {s_in[CW-2:0], 1'b0};
        d_q[j]    <= d_in;
        den_q[j]  <= den_in;
        neg_q[j]  <= neg_in;
        base_q[j] <= base_in;
      end
    end
  end

  // Signed offset added to the edge start.
  assign quo_neg = -quo_q[CW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coord_q <= base_q[CW-1] + (neg_q[CW-1] ? quo_neg : quo_q[CW-1]);
    end
  end

  assign coord_o = coord_q;

endmodule

### rtl/core/tps_emit.sv
// ----------------------------------------------------------------------------
// tps_emit
// Holds one finished triangle and sends its pieces, one per cycle, through
// registered result ports in the fixed case order.
// ----------------------------------------------------------------------------
module tps_emit #(
  parameter int CW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  tps_pkg::plan_t                plan_i,
  input  logic [2:0][2:0][CW-1:0]       vtx_i,
  input  logic [1:0][2:0][CW-1:0]       cut_i,
  output logic                          ready_o,
  output logic                          strobe_o,
  output logic [1:0]                    kind_o,
  output logic [2:0][2:0][CW-1:0]       v_o,
  output logic                          last_o
);

  logic                     active_q;
  logic [1:0]               idx_q;
  tps_pkg::plan_t           plan_q;
  logic [2:0][2:0][CW-1:0]  vtx_q;
  logic [1:0][2:0][CW-1:0]  cut_q;
  logic                     strobe_q;
  logic [1:0]               kind_q;
  logic [2:0][2:0][CW-1:0]  v_q;
  logic                     last_q;

  logic [2:0]               cnt;
  logic                     is_last;
  logic                     take;
  logic                     seg;
  tps_pkg::sel_e            seg0;
  tps_pkg::sel_e            seg1;
  tps_pkg::sel_e            sel [3];
  logic [1:0]               kind;
  logic [1:0]               k_a;
  logic [1:0]               k_b;
  logic [1:0]               k_c;
  logic [2:0][2:0][CW-1:0]  v_d;

  function automatic logic [2:0][CW-1:0] pick(
    tps_pkg::sel_e s,
    logic [2:0][2:0][CW-1:0] vt,
    logic [1:0][2:0][CW-1:0] ct
  );
    logic [2:0][CW-1:0] r;
    case (s)
      tps_pkg::SEL_A: r = vt[0];
      tps_pkg::SEL_B: r = vt[1];
      tps_pkg::SEL_C: r = vt[2];
      tps_pkg::SEL_P: r = ct[0];
      tps_pkg::SEL_Q: r = ct[1];
      default:        r = '0;
    endcase
    return r;
  endfunction

  // Number of pieces and the segment of a triangle with no positive vertex.
  always_comb begin
    seg  = 1'b1;
    seg0 = tps_pkg::SEL_B;
    seg1 = tps_pkg::SEL_C;
    if (plan_q.a_zero && plan_q.b_zero) begin
      seg0 = tps_pkg::SEL_A;
      seg1 = tps_pkg::SEL_B;
    end else if (plan_q.a_zero && plan_q.c_zero) begin
      seg0 = tps_pkg::SEL_A;
      seg1 = tps_pkg::SEL_C;
    end else if (!(plan_q.b_zero && plan_q.c_zero)) begin
      seg = 1'b0;
    end
    case (plan_q.cs)
      tps_pkg::CS_NEG: cnt = seg ? 3'd2 : 3'd1;
      tps_pkg::CS_POS: cnt = 3'd1;
      tps_pkg::CS_AB, tps_pkg::CS_AC, tps_pkg::CS_BC: cnt = 3'd4;
      default:         cnt = 3'd3;
    endcase
  end

  assign is_last = ({1'b0, idx_q} == cnt - 3'd1);
  assign ready_o = !active_q || is_last;
  assign take    = valid_i && ready_o;

  // Kind and vertex sources of the current piece.
  always_comb begin
    k_a = plan_q.a_neg ? tps_pkg::KIND_NEG : tps_pkg::KIND_POS;
    k_b = plan_q.b_neg ? tps_pkg::KIND_NEG : tps_pkg::KIND_POS;
    k_c = plan_q.c_neg ? tps_pkg::KIND_NEG : tps_pkg::KIND_POS;
    kind   = tps_pkg::KIND_NEG;
    sel[0] = tps_pkg::SEL_A;
    sel[1] = tps_pkg::SEL_B;
    sel[2] = tps_pkg::SEL_C;
    case (plan_q.cs)
      tps_pkg::CS_NEG: begin
        if (seg && idx_q == 2'd0) begin
          kind   = tps_pkg::KIND_SEG;
          sel[0] = seg0;
          sel[1] = seg1;
          sel[2] = tps_pkg::SEL_ZERO;
        end
      end
      tps_pkg::CS_POS: kind = tps_pkg::KIND_POS;
      tps_pkg::CS_AB: begin
        case (idx_q)
          2'd0: begin
            kind = k_a; sel[0] = tps_pkg::SEL_A; sel[1] = tps_pkg::SEL_B;
            sel[2] = tps_pkg::SEL_P;
          end
          2'd1: begin
            kind = k_a; sel[0] = tps_pkg::SEL_A; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_Q;
          end
          2'd2: begin
            kind = tps_pkg::KIND_SEG; sel[0] = tps_pkg::SEL_P;
            sel[1] = tps_pkg::SEL_Q; sel[2] = tps_pkg::SEL_ZERO;
          end
          default: begin
            kind = k_c; sel[0] = tps_pkg::SEL_Q; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_C;
          end
        endcase
      end
      tps_pkg::CS_AC: begin
        case (idx_q)
          2'd0: begin
            kind = k_a; sel[0] = tps_pkg::SEL_A; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_C;
          end
          2'd1: begin
            kind = k_a; sel[0] = tps_pkg::SEL_A; sel[1] = tps_pkg::SEL_Q;
            sel[2] = tps_pkg::SEL_P;
          end
          2'd2: begin
            kind = tps_pkg::KIND_SEG; sel[0] = tps_pkg::SEL_Q;
            sel[1] = tps_pkg::SEL_P; sel[2] = tps_pkg::SEL_ZERO;
          end
          default: begin
            kind = k_b; sel[0] = tps_pkg::SEL_P; sel[1] = tps_pkg::SEL_Q;
            sel[2] = tps_pkg::SEL_B;
          end
        endcase
      end
      tps_pkg::CS_BC: begin
        case (idx_q)
          2'd0: begin
            kind = k_b; sel[0] = tps_pkg::SEL_B; sel[1] = tps_pkg::SEL_C;
            sel[2] = tps_pkg::SEL_P;
          end
          2'd1: begin
            kind = k_b; sel[0] = tps_pkg::SEL_B; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_Q;
          end
          2'd2: begin
            kind = tps_pkg::KIND_SEG; sel[0] = tps_pkg::SEL_P;
            sel[1] = tps_pkg::SEL_Q; sel[2] = tps_pkg::SEL_ZERO;
          end
          default: begin
            kind = k_a; sel[0] = tps_pkg::SEL_Q; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_A;
          end
        endcase
      end
      tps_pkg::CS_ZA: begin
        case (idx_q)
          2'd0: begin
            kind = k_b; sel[0] = tps_pkg::SEL_A; sel[1] = tps_pkg::SEL_B;
            sel[2] = tps_pkg::SEL_P;
          end
          2'd1: begin
            kind = k_c; sel[0] = tps_pkg::SEL_A; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_C;
          end
          default: begin
            kind = tps_pkg::KIND_SEG; sel[0] = tps_pkg::SEL_A;
            sel[1] = tps_pkg::SEL_P; sel[2] = tps_pkg::SEL_ZERO;
          end
        endcase
      end
      tps_pkg::CS_ZB: begin
        case (idx_q)
          2'd0: begin
            kind = k_c; sel[0] = tps_pkg::SEL_B; sel[1] = tps_pkg::SEL_C;
            sel[2] = tps_pkg::SEL_P;
          end
          2'd1: begin
            kind = k_a; sel[0] = tps_pkg::SEL_B; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_A;
          end
          default: begin
            kind = tps_pkg::KIND_SEG; sel[0] = tps_pkg::SEL_B;
            sel[1] = tps_pkg::SEL_P; sel[2] = tps_pkg::SEL_ZERO;
          end
        endcase
      end
      default: begin
        case (idx_q)
          2'd0: begin
            kind = k_a; sel[0] = tps_pkg::SEL_C; sel[1] = tps_pkg::SEL_A;
            sel[2] = tps_pkg::SEL_P;
          end
          2'd1: begin
            kind = k_b; sel[0] = tps_pkg::SEL_C; sel[1] = tps_pkg::SEL_P;
            sel[2] = tps_pkg::SEL_B;
          end
          default: begin
            kind = tps_pkg::KIND_SEG; sel[0] = tps_pkg::SEL_C;
            sel[1] = tps_pkg::SEL_P; sel[2] = tps_pkg::SEL_ZERO;
          end
        endcase
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      v_d[i] = pick(sel[i], vtx_q, cut_q);
    end
  end

  // Piece sequencing and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= active_q;
      last_q   <= active_q && is_last;
      if (take) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (active_q && is_last) begin
        active_q <= 1'b0;
      end else if (active_q) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Held triangle and result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      plan_q <= plan_i;
      vtx_q  <= vtx_i;
      cut_q  <= cut_i;
    end
    kind_q <= kind;
    v_q    <= v_d;
  end

  assign strobe_o = strobe_q;
  assign kind_o   = kind_q;
  assign v_o      = v_q;
  assign last_o   = last_q;

  // A finished triangle is refused only while pieces are still going out.
  a_refuse_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> active_q) else $error("emit refused while idle");

  // A taken triangle makes the sequencer active at its first piece in the next cycle.
  a_take_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (active_q && idx_q == 2'd0)) else $error("take did not start emission");

  // The last-piece flag comes only with a strobe.
  a_last_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> strobe_q) else $error("last piece without strobe");

  // The piece index never runs past the piece count.
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ({1'b0, idx_q} < cnt)) else $error("piece index out of range");

endmodule

### bench/triangle_plane_splitter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_plane_splitter_checker
// Watches the configuration, triangle and piece ports of the splitter. It
// keeps its own copy of the plane, works out the pieces of every accepted
// triangle, and compares each piece field by field against the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module triangle_plane_splitter_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [8:0][31:0] tri_i,
  input  logic             strobe_i,
  input  logic [1:0]       kind_i,
  input  logic [8:0][31:0] piece_i,
  input  logic             last_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               pieces_o,
  output int               cuts_o
);

  typedef logic signed [127:0] wide_t;
  typedef logic [2:0][31:0] vtx_t;

  typedef struct {
    logic [1:0]       kind;
    logic [8:0][31:0] v;
    logic             last;
  } piece_t;

  piece_t     piece_q[$];
  logic [31:0] plane_pt[3];
  logic [31:0] plane_nrm[3];

  // Exact signed distance n.P - n.O, unscaled.
  function automatic wide_t plane_dist(vtx_t p);
    wide_t acc;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      acc += wide_t'(signed'(plane_nrm[k])) * wide_t'(signed'(p[k]));
      acc -= wide_t'(signed'(plane_nrm[k])) * wide_t'(signed'(plane_pt[k]));
    end
    return acc;
  endfunction

  function automatic int sign_of(wide_t d);
    return (d < 0) ? -1 : ((d == 0) ? 0 : 1);
  endfunction

  // Point where edge P-Q meets the plane, offset truncated toward zero.
  function automatic vtx_t edge_cut(vtx_t p, vtx_t q);
    vtx_t  r;
    wide_t d1;
    wide_t den;
    wide_t num;
    wide_t off;
    d1  = plane_dist(p);
    den = d1 - plane_dist(q);
    for (int k = 0; k < 3; k++) begin
      num  = (wide_t'(signed'(q[k])) - wide_t'(signed'(p[k]))) * d1;
      off  = num / den;
      r[k] = p[k] + off[31:0];
    end
    return r;
  endfunction

  function automatic void add_piece(logic [1:0] kind, vtx_t a, vtx_t b, vtx_t c);
    piece_t pc;
    pc.kind = kind;
    pc.v    = {c, b, a};
    pc.last = 1'b0;
    piece_q.insert(piece_q.size(), pc);
  endfunction

  function automatic logic [1:0] side_kind(int s);
    return (s < 0) ? tps_pkg::KIND_NEG : tps_pkg::KIND_POS;
  endfunction

  // Pieces of one triangle in the fixed case order.
  function automatic void split_triangle(logic [8:0][31:0] t);
    vtx_t a;
    vtx_t b;
    vtx_t c;
    vtx_t p;
    vtx_t q;
    vtx_t z;
    int   sa;
    int   sb;
    int   sc;
    a  = t[2:0];
    b  = t[5:3];
    c  = t[8:6];
    z  = '0;
    sa = sign_of(plane_dist(a));
    sb = sign_of(plane_dist(b));
    sc = sign_of(plane_dist(c));
    if (sa <= 0 && sb <= 0 && sc <= 0) begin
      if (sa == 0 && sb == 0) add_piece(tps_pkg::KIND_SEG, a, b, z);
      else if (sa == 0 && sc == 0) add_piece(tps_pkg::KIND_SEG, a, c, z);
      else if (sb == 0 && sc == 0) add_piece(tps_pkg::KIND_SEG, b, c, z);
      add_piece(tps_pkg::KIND_NEG, a, b, c);
    end else if (sa >= 0 && sb >= 0 && sc >= 0) begin
      add_piece(tps_pkg::KIND_POS, a, b, c);
    end else if (sa != 0 && sb != 0 && sc != 0) begin
      cuts_o++;
      if (sa == sb) begin
        p = edge_cut(b, c);
        q = edge_cut(a, c);
        add_piece(side_kind(sa), a, b, p);
        add_piece(side_kind(sa), a, p, q);
        add_piece(tps_pkg::KIND_SEG, p, q, z);
        add_piece(side_kind(sc), q, p, c);
      end else if (sa == sc) begin
        p = edge_cut(c, b);
        q = edge_cut(a, b);
        add_piece(side_kind(sa), a, p, c);
        add_piece(side_kind(sa), a, q, p);
        add_piece(tps_pkg::KIND_SEG, q, p, z);
        add_piece(side_kind(sb), p, q, b);
      end else begin
        p = edge_cut(c, a);
        q = edge_cut(b, a);
        add_piece(side_kind(sb), b, c, p);
        add_piece(side_kind(sb), b, p, q);
        add_piece(tps_pkg::KIND_SEG, p, q, z);
        add_piece(side_kind(sa), q, p, a);
      end
    end else if (sa == 0) begin
      cuts_o++;
      p = edge_cut(b, c);
      add_piece(side_kind(sb), a, b, p);
      add_piece(side_kind(sc), a, p, c);
      add_piece(tps_pkg::KIND_SEG, a, p, z);
    end else if (sb == 0) begin
      cuts_o++;
      p = edge_cut(c, a);
      add_piece(side_kind(sc), b, c, p);
      add_piece(side_kind(sa), b, p, a);
      add_piece(tps_pkg::KIND_SEG, b, p, z);
    end else begin
      cuts_o++;
      p = edge_cut(a, b);
      add_piece(side_kind(sa), c, a, p);
      add_piece(side_kind(sb), c, p, b);
      add_piece(tps_pkg::KIND_SEG, c, p, z);
    end
    piece_q[$].last = 1'b1;
  endfunction

  // Track the plane, queue the pieces of each request, check each piece.
  always @(posedge clk_i or negedge rst_ni) begin
    piece_t exp_pc;
    string  axis;
    if (!rst_ni) begin
      plane_pt     = '{32'd0, 32'd0, 32'd0};
      plane_nrm    = '{32'd0, 32'd0, 32'd65536};
      piece_q.delete();
      fail_count_o = 0;
      pieces_o     = 0;
      cuts_o       = 0;
    end else begin
      if (strobe_i) begin
        pieces_o++;
        if (piece_q.size() == 0) begin
          $error("piece arrived with none outstanding");
          fail_count_o++;
        end else begin
          exp_pc = piece_q.pop_front();
          if (kind_i !== exp_pc.kind) begin
            $error("piece_kind: expected %0d, got %0d", exp_pc.kind, kind_i);
            fail_count_o++;
          end
          for (int i = 0; i < 9; i++) begin
            axis = (i % 3 == 0) ? "x" : ((i % 3 == 1) ? "y" : "z");
            if (piece_i[i] !== exp_pc.v[i]) begin
              $error("v%0d_%s: expected %h, got %h", i / 3, axis, exp_pc.v[i],
                     piece_i[i]);
              fail_count_o++;
            end
          end
          if (last_i !== exp_pc.last) begin
            $error("last_piece: expected %0d, got %0d", exp_pc.last, last_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) split_triangle(tri_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tps_pkg::REG_PT_X:  plane_pt[0]  = cfg_data_i;
          tps_pkg::REG_PT_Y:  plane_pt[1]  = cfg_data_i;
          tps_pkg::REG_PT_Z:  plane_pt[2]  = cfg_data_i;
          tps_pkg::REG_NRM_X: plane_nrm[0] = cfg_data_i;
          tps_pkg::REG_NRM_Y: plane_nrm[1] = cfg_data_i;
          tps_pkg::REG_NRM_Z: plane_nrm[2] = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = piece_q.size();
  end

endmodule

### bench/triangle_plane_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_plane_splitter_tb
// Drives triangles and plane settings into the splitter with random gaps.
// Directed triangles hit every split case, vertices on the plane and the
// coordinate extremes; random triangles follow under several planes,
// including extreme and zero normals. A separate checker predicts the pieces.
// ----------------------------------------------------------------------------
module triangle_plane_splitter_tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 60;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_idx = tps_pkg::REG_PT_X;
  logic [31:0]      cfg_data = '0;
  logic             start = 1'b0;
  logic             busy;
  logic [8:0][31:0] tri_data = '0;
  logic             strobe;
  logic [1:0]       piece_kind;
  logic [8:0][31:0] piece_data;
  logic             last_piece;
  int               fail_count;
  int               pending;
  int               pieces;
  int               cuts;
  int               accepted = 0;
  int               idle_cycles = 0;
  logic [31:0]      plane_pt[3] = '{32'd0, 32'd0, 32'd0};
  logic [31:0]      plane_nrm[3] = '{32'd0, 32'd0, 32'd65536};

  always #5 clk_i = ~clk_i;

  triangle_plane_splitter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .start        (start),
    .busy         (busy),
    .a_x_i        (tri_data[0]),
    .a_y_i        (tri_data[1]),
    .a_z_i        (tri_data[2]),
    .b_x_i        (tri_data[3]),
    .b_y_i        (tri_data[4]),
    .b_z_i        (tri_data[5]),
    .c_x_i        (tri_data[6]),
    .c_y_i        (tri_data[7]),
    .c_z_i        (tri_data[8]),
    .strobe       (strobe),
    .piece_kind_o (piece_kind),
    .v0_x_o       (piece_data[0]),
    .v0_y_o       (piece_data[1]),
    .v0_z_o       (piece_data[2]),
    .v1_x_o       (piece_data[3]),
    .v1_y_o       (piece_data[4]),
    .v1_z_o       (piece_data[5]),
    .v2_x_o       (piece_data[6]),
    .v2_y_o       (piece_data[7]),
    .v2_z_o       (piece_data[8]),
    .last_piece_o (last_piece)
  );

  triangle_plane_splitter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .start_i      (start),
    .busy_i       (busy),
    .tri_i        (tri_data),
    .strobe_i     (strobe),
    .kind_i       (piece_kind),
    .piece_i      (piece_data),
    .last_i       (last_piece),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pieces_o     (pieces),
    .cuts_o       (cuts)
  );

  // Watchdog on cycles in which no request, no piece and no plane write is taken.
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("triangle_plane_splitter_tb NOT OK");
      $finish;
    end
  end

  // Wait until every piece has come, then let the pipeline settle.
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_plane(logic [2:0] idx, logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (idx <= tps_pkg::REG_PT_Z) plane_pt[idx] = value;
    else plane_nrm[idx - tps_pkg::REG_NRM_X] = value;
  endtask

  // Stop sending, wait for every piece, then load a new plane.
  task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
    start <= 1'b0;
    drain();
    write_plane(tps_pkg::REG_PT_X, px);
    write_plane(tps_pkg::REG_PT_Y, py);
    write_plane(tps_pkg::REG_PT_Z, pz);
    write_plane(tps_pkg::REG_NRM_X, nx);
    write_plane(tps_pkg::REG_NRM_Y, ny);
    write_plane(tps_pkg::REG_NRM_Z, nz);
  endtask

  // One request: random gap, then hold start until the block takes it.
  task automatic send_triangle(logic [8:0][31:0] t);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    tri_data <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    accepted++;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 2 * 4096)) - 4096) <<< 16;
      default: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
    endcase
  endfunction

  // Random triangle; when the plane is axis-aligned, some vertices are put on it.
  function automatic logic [8:0][31:0] rand_triangle();
    logic [8:0][31:0] t;
    int               mode;
    int               ax;
    mode = $urandom_range(0, 4);
    if (mode > 2) mode = 2;
    for (int i = 0; i < 9; i++) t[i] = rand_coord(mode);
    ax = -1;
    for (int k = 0; k < 3; k++)
      if (plane_nrm[k] != 0 && plane_nrm[(k + 1) % 3] == 0 && plane_nrm[(k + 2) % 3] == 0)
        ax = k;
    if (ax >= 0)
      for (int v = 0; v < 3; v++)
        if ($urandom_range(0, 4) == 0) t[v * 3 + ax] = plane_pt[ax];
    return t;
  endfunction

  function automatic logic [8:0][31:0] zed(int az, int bz, int cz);
    logic [8:0][31:0] t;
    t = '{32'd0, 32'd0, 32'(cz), 32'h0003_0000, 32'h0001_0000, 32'(bz),
          32'h0001_0000, 32'h0002_0000, 32'(az)};
    t[8] = 32'(cz);
    t[5] = 32'(bz);
    t[2] = 32'(az);
    return t;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_triangle(rand_triangle());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default plane z = 0, every split case and on-plane pattern.
    send_triangle(zed(-5, -3, -1));
    send_triangle(zed(5, 3, 1));
    send_triangle(zed(0, 0, -4));
    send_triangle(zed(0, -4, 0));
    send_triangle(zed(-4, 0, 0));
    send_triangle(zed(0, 0, 0));
    send_triangle(zed(0, 0, 7));
    send_triangle(zed(3 << 16, 1 << 16, -7 << 16));
    send_triangle(zed(3 << 16, -1 << 16, 7 << 16));
    send_triangle(zed(-3 << 16, 1 << 16, 7 << 16));
    send_triangle(zed(-3, -9, 7));
    send_triangle(zed(0, 1 << 16, -5 << 16));
    send_triangle(zed(-5, 0, 3));
    send_triangle(zed(9, -2, 0));
    send_triangle(zed(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_triangle(zed(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_triangle('{9{32'h7FFF_FFFF}});
    send_triangle('{9{32'h8000_0000}});
    send_triangle('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1});
    random_phase(50);

    // Offset axis plane along x, pieces all drained before the change.
    set_plane(32'h0003_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0);
    send_triangle('{32'd0, 32'd0, 32'h0003_0000, 32'd0, 32'd0, 32'h0003_0000,
                    32'd0, 32'd0, 32'h0009_0000});
    random_phase(55);

    // Oblique plane with random small normal.
    set_plane(rand_coord(2), rand_coord(2), rand_coord(2),
              rand_coord(2), rand_coord(2), rand_coord(2));
    random_phase(55);

    // Extreme registers.
    set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    random_phase(50);
    set_plane(32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    random_phase(50);

    // Zero normal: every vertex is on the plane.
    set_plane($urandom(), $urandom(), $urandom(), 32'h0, 32'h0, 32'h0);
    random_phase(20);

    // A fully random plane last.
    set_plane($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_phase(30);

    start <= 1'b0;
    drain();

    $display("Sent %0d triangles (%0d split across the plane), checked %0d pieces",
             accepted, cuts, pieces);
    $display("under seven plane settings incl. reset, extreme and zero normals.");
    if (fail_count == 0) begin
      $display("triangle_plane_splitter_tb OK");
    end else begin
      $display("triangle_plane_splitter_tb NOT OK");
    end
    $finish;
  end

endmodule
